/* src/ctb_pkg.sv */
`default_nettype none

package ctb_pkg;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_START  = 3'd2,
    KIND_PAUSE  = 3'd3,
    KIND_RESET  = 3'd4,
    KIND_DELETE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    MODE_FREE     = 3'd0,
    MODE_RESET    = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_PAUSED   = 3'd3,
    MODE_NOTIFIED = 3'd4
  } mode_t;

  localparam int TIME_W  = 64;
  localparam int CHAN_W  = 4;
  localparam int COUNT_W = 5;
  localparam int MASK_W  = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] preset_ms;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] expired_count;
    logic [MASK_W-1:0]  expired_mask;
    logic [2:0]         channel_mode;
    logic [TIME_W-1:0]  channel_remaining;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch the accepted item, clear tick results and sweep index
    logic prep;         // read preset of the addressed channel
    logic exec;         // apply a channel command
    logic sweep_issue;  // read one channel for the tick sweep
    logic rd_issue;     // read remaining of the addressed channel
    logic out_load;     // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic sweep_last;
    logic pipe_busy;
  } stat_t;

endpackage

`default_nettype wire

/* src/ctb_ctrl.sv */
`default_nettype none

module ctb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ctb_pkg::cmd_t       cmd,
  input  wire ctb_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_SWEEP,
    S_DRAIN,
    S_READ,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.is_tick ? S_SWEEP : S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_SWEEP: begin
        cmd.sweep_issue = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ctb_datapath.sv */
`default_nettype none

module ctb_datapath #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctb_pkg::in_item_t in_item,
  input  wire ctb_pkg::cmd_t     cmd,
  output ctb_pkg::stat_t         stat,
  output ctb_pkg::out_item_t     out_item
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TW    = ctb_pkg::TIME_W;
  localparam int CW    = ctb_pkg::COUNT_W;
  localparam int MW    = ctb_pkg::MASK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  // latched item
  logic [2:0]      kind_r;
  logic [IDX_W-1:0] idx_r;
  logic            ch_valid_r;
  logic [TW-1:0]   now_r;
  logic [TW-1:0]   preset_r;

  // channel modes in flops, reset to free
  ctb_pkg::mode_t  mode_r [NUM_CHANNELS];

  // channel stores
  logic [TW-1:0]   preset_mem [NUM_CHANNELS];
  logic [TW-1:0]   rem_mem    [NUM_CHANNELS];
  logic [TW-1:0]   start_mem  [NUM_CHANNELS];
  logic [TW-1:0]   preset_rd_r;
  logic [TW-1:0]   rem_rd_r;
  logic [TW-1:0]   start_rd_r;

  // sweep pipeline
  logic [IDX_W-1:0] sweep_idx_r;
  logic             p1_v_r;
  logic [IDX_W-1:0] p1_idx_r;
  logic             p2_v_r;
  logic [IDX_W-1:0] p2_idx_r;
  logic [TW-1:0]    p2_elap_r;
  logic [TW-1:0]    p2_rem_r;

  logic [CW-1:0]    count_r;
  logic [MW-1:0]    mask_r;
  ctb_pkg::out_item_t out_r;

  logic             ch_valid_in;
  logic             ch_live;
  logic [TW:0]      diff;
  logic [TW-1:0]    sweep_rem;
  logic             p2_running;
  logic             p2_expire;

  logic             rem_we;
  logic [IDX_W-1:0] rem_waddr;
  logic [TW-1:0]    rem_wdata;
  logic [IDX_W-1:0] rem_raddr;
  logic             start_we;
  logic [IDX_W-1:0] start_waddr;
  logic             preset_we;

  assign ch_valid_in = ({{(32 - ctb_pkg::CHAN_W){1'b0}}, in_item.channel})
                       < 32'(NUM_CHANNELS);
  assign ch_live     = ch_valid_r && (mode_r[idx_r] != ctb_pkg::MODE_FREE);

  // saturating countdown: remaining > elapsed keeps the difference, else zero
  assign diff       = {1'b0, p2_rem_r} - {1'b0, p2_elap_r};
  assign sweep_rem  = (diff[TW] || (diff[TW-1:0] == '0)) ? '0 : diff[TW-1:0];
  assign p2_running = p2_v_r && (mode_r[p2_idx_r] == ctb_pkg::MODE_RUNNING);
  assign p2_expire  = p2_running && (sweep_rem == '0);

  assign stat.is_tick    = (kind_r == ctb_pkg::KIND_TICK);
  assign stat.sweep_last = (sweep_idx_r == LAST_IDX);
  assign stat.pipe_busy  = p1_v_r || p2_v_r;

  // store write ports
  always_comb begin
    rem_we      = 1'b0;
    rem_waddr   = idx_r;
    rem_wdata   = preset_r;
    start_we    = 1'b0;
    start_waddr = idx_r;
    preset_we   = 1'b0;
    if (p2_running) begin
      rem_we      = 1'b1;
      rem_waddr   = p2_idx_r;
      rem_wdata   = sweep_rem;
      start_we    = 1'b1;
      start_waddr = p2_idx_r;
    end else if (cmd.exec) begin
      unique case (kind_r)
        ctb_pkg::KIND_ADD: begin
          preset_we = ch_valid_r;
          rem_we    = ch_valid_r;
        end
        ctb_pkg::KIND_START: start_we = ch_live;
        ctb_pkg::KIND_RESET: begin
          rem_we    = ch_live;
          rem_wdata = preset_rd_r;
        end
        default: ;
      endcase
    end
  end

  assign rem_raddr = cmd.sweep_issue ? sweep_idx_r : idx_r;

  always_ff @(posedge clk) begin
    if (preset_we) begin
      preset_mem[idx_r] <= preset_r;
    end
    if (cmd.prep) begin
      preset_rd_r <= preset_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (cmd.sweep_issue || cmd.rd_issue) begin
      rem_rd_r <= rem_mem[rem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_waddr] <= now_r;
    end
    if (cmd.sweep_issue) begin
      start_rd_r <= start_mem[sweep_idx_r];
    end
  end

  // item latch and sweep stages
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_item.kind;
      idx_r      <= IDX_W'(in_item.channel);
      ch_valid_r <= ch_valid_in;
      now_r      <= in_item.now_ms;
      preset_r   <= in_item.preset_ms;
    end
    if (p1_v_r) begin
      p2_idx_r  <= p1_idx_r;
      p2_elap_r <= now_r - start_rd_r;
      p2_rem_r  <= rem_rd_r;
    end
    if (cmd.sweep_issue) begin
      p1_idx_r <= sweep_idx_r;
    end
    if (cmd.out_load) begin
      out_r.expired_count <= count_r;
      out_r.expired_mask  <= mask_r;
      if (ch_live) begin
        out_r.channel_mode      <= mode_r[idx_r];
        out_r.channel_remaining <= rem_rd_r;
      end else begin
        out_r.channel_mode      <= ctb_pkg::MODE_FREE;
        out_r.channel_remaining <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      sweep_idx_r <= '0;
      count_r     <= '0;
      mask_r      <= '0;
    end else begin
      p1_v_r <= cmd.sweep_issue;
      p2_v_r <= p1_v_r;
      if (cmd.capture) begin
        sweep_idx_r <= '0;
        count_r     <= '0;
        mask_r      <= '0;
      end else begin
        if (cmd.sweep_issue) begin
          sweep_idx_r <= sweep_idx_r + 1'b1;
        end
        if (p2_expire) begin
          if (count_r != ctb_pkg::COUNT_MAX) begin
            count_r <= count_r + 1'b1;
          end
          // channels at 16 and above have no mask bit
          mask_r <= mask_r | (MW'(1) << p2_idx_r);
        end
      end
    end
  end

  // channel modes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode_r[i] <= ctb_pkg::MODE_FREE;
      end
    end else if (p2_expire) begin
      mode_r[p2_idx_r] <= ctb_pkg::MODE_NOTIFIED;
    end else if (cmd.exec) begin
      unique case (kind_r)
        ctb_pkg::KIND_ADD: begin
          if (ch_valid_r) mode_r[idx_r] <= ctb_pkg::MODE_RESET;
        end
        ctb_pkg::KIND_START: begin
          if (ch_live) mode_r[idx_r] <= ctb_pkg::MODE_RUNNING;
        end
        ctb_pkg::KIND_PAUSE: begin
          if (ch_live) mode_r[idx_r] <= ctb_pkg::MODE_PAUSED;
        end
        ctb_pkg::KIND_RESET: begin
          if (ch_live) mode_r[idx_r] <= ctb_pkg::MODE_RESET;
        end
        ctb_pkg::KIND_DELETE: begin
          if (ch_live) mode_r[idx_r] <= ctb_pkg::MODE_FREE;
        end
        default: ;
      endcase
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

/* src/countdown_timer_bank_core.sv */
// A command item is decoded, applied, then its remaining is read and its result loaded;
// a tick item runs a sweep that reads each channel's stores once, then drains and reads.
// No new item is taken until the previous result is loaded, which waits for a free output.
// A new item is taken while the previous result still waits on the output.
// Reset (rst_n, synchronous): all channels free, no result pending; the preset,
// remaining and start stores are not cleared.
`default_nettype none

module countdown_timer_bank_core #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ctb_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ctb_pkg::out_item_t      out_item
);

  ctb_pkg::cmd_t  cmd;
  ctb_pkg::stat_t stat;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ctb_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
